// File: hw/rtl/bfie_pkg.sv
// Package for the tape-language instruction executor.
// Holds command byte codes, status and request codes, field widths and the
// tape port control struct. It depends on nothing.
package bfie_pkg;

  // Default memory depths.
  localparam int CODE_DEPTH_DEF  = 4096;
  localparam int TAPE_DEPTH_DEF  = 32768;
  localparam int STACK_DEPTH_DEF = 512;

  // Fixed field widths of the transactions.
  localparam int BYTE_W     = 8;
  localparam int LOAD_W     = 12;
  localparam int PC_OUT_W   = 12;
  localparam int HEAD_OUT_W = 15;
  localparam int STATUS_W   = 2;

  // Request kinds.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Command bytes.
  localparam logic [BYTE_W-1:0] OP_HALT  = 8'h00;
  localparam logic [BYTE_W-1:0] OP_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] OP_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] OP_OUT   = 8'h2E;
  localparam logic [BYTE_W-1:0] OP_IN    = 8'h2C;
  localparam logic [BYTE_W-1:0] OP_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] OP_CLOSE = 8'h5D;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HALT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNF  = 2'd3;

  // Control of the tape port: write and read strobes.
  typedef struct packed {
    logic wr;
    logic rd;
  } tape_ctl_t;

endpackage

// File: hw/rtl/bfie_req_if.sv
// Request channel of the executor: valid/ready plus the request payload.
// Depends on bfie_pkg for field widths.
interface bfie_req_if;
  import bfie_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [LOAD_W-1:0] load_address;
  logic [BYTE_W-1:0] program_byte;
  logic [BYTE_W-1:0] read_value;

  modport source (output valid, req_type, load_address, program_byte, read_value,
                  input ready);
  modport sink (input valid, req_type, load_address, program_byte, read_value,
                output ready);
endinterface

// File: hw/rtl/bfie_rsp_if.sv
// Result channel of the executor: valid/ready plus the result payload.
// Depends on bfie_pkg for field widths.
interface bfie_rsp_if;
  import bfie_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PC_OUT_W-1:0]   program_position;
  logic                  emit_valid;
  logic [BYTE_W-1:0]     emit_value;
  logic [BYTE_W-1:0]     cell_now;
  logic [HEAD_OUT_W-1:0] head_now;
  logic [STATUS_W-1:0]   status;

  modport source (output valid, program_position, emit_valid, emit_value, cell_now,
                  head_now, status, input ready);
  modport sink (input valid, program_position, emit_valid, emit_value, cell_now,
                head_now, status, output ready);
endinterface

// File: hw/rtl/bf_instruction_executor_core.sv
// Top level of the tape-language instruction executor.
// Depends on bfie_pkg, bfie_req_if, bfie_rsp_if and bfie_tape.

// The block takes load transactions that fill the program memory and step
// transactions that each execute one command, and returns one result per
// request. After reset the tape is zeroed by a sweep over all TAPE_DEPTH cells
// (32768 by default) during which no request is taken. A load, or a step while
// halted, goes straight to the result stage, where it waits until the result
// register is free; every other command first fetches its byte through the
// registered program read port. A '[' on a zero cell walks the program one
// byte per cycle through that port. The current cell is the tape read
// register and the top of the loop stack is the stack read register, so neither
// costs an extra read. Status reports ok, halted, loop stack overflow or
// underflow; the error codes show once and the block stays halted afterwards.
module bf_instruction_executor_core #(
  parameter int CODE_DEPTH  = bfie_pkg::CODE_DEPTH_DEF,
  parameter int TAPE_DEPTH  = bfie_pkg::TAPE_DEPTH_DEF,
  parameter int STACK_DEPTH = bfie_pkg::STACK_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  bfie_req_if.sink   req,
  bfie_rsp_if.source rsp
);
  import bfie_pkg::*;

  localparam int PW = $clog2(CODE_DEPTH);
  localparam int HW = $clog2(TAPE_DEPTH);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  localparam logic [PW-1:0] PC_LAST   = PW'(CODE_DEPTH - 1);
  localparam logic [HW-1:0] HEAD_LAST = HW'(TAPE_DEPTH - 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Architectural state and sequencer registers.
  logic [2:0]          state, state_next;
  logic [PW-1:0]       pc, pc_next;
  logic [HW-1:0]       head, head_next;
  logic [DW-1:0]       depth, depth_next;
  logic                halted, halted_next;
  logic [STATUS_W-1:0] err, err_next;
  logic                emit, emit_next;
  logic [BYTE_W-1:0]   emit_byte, emit_byte_next;
  logic [PW-1:0]       scan_addr, scan_addr_next;
  logic [PW-1:0]       nest, nest_next;
  logic [BYTE_W-1:0]   in_byte, in_byte_next;

  // Memory ports.
  logic [BYTE_W-1:0] prog_mem [CODE_DEPTH];
  logic              prog_we, prog_re;
  logic [PW-1:0]     prog_waddr, prog_raddr;
  logic [BYTE_W-1:0] prog_rdata;

  logic [PW-1:0] stk_mem [STACK_DEPTH];
  logic          stk_we, stk_re;
  logic [SW-1:0] stk_waddr, stk_raddr;
  logic [PW-1:0] stk_wdata, stk_rdata;

  tape_ctl_t         tape_ctl;
  logic [HW-1:0]     tape_addr;
  logic [BYTE_W-1:0] tape_wdata, tape_rdata;
  logic              tape_busy;

  // Handshake and helper signals.
  logic                    accept, out_free, load_out, load_in_range;
  logic [PW+LOAD_W-1:0]    la_ext;
  logic [PW+PC_OUT_W-1:0]  pc_ext;
  logic [HW+HEAD_OUT_W-1:0] head_ext;
  logic [DW-1:0]           depth_m2;
  logic                    top_here, pc_at_last, scan_at_last;
  logic [STATUS_W-1:0]     cur_status;

  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE) || ((state == S_DONE) && out_free);
  assign accept = req.valid && req.ready;

  assign la_ext = {{PW{1'b0}}, req.load_address};
  assign load_in_range = 32'(req.load_address) < 32'(CODE_DEPTH);
  assign prog_waddr = la_ext[PW-1:0];
  assign prog_we = accept && (req.req_type == REQ_LOAD) && load_in_range;

  assign depth_m2 = depth - DW'(2);
  assign top_here = (depth != '0) && (stk_rdata == pc);
  assign pc_at_last = (pc == PC_LAST);
  assign scan_at_last = (scan_addr == PC_LAST);

  assign pc_ext = {{PC_OUT_W{1'b0}}, pc};
  assign head_ext = {{HEAD_OUT_W{1'b0}}, head};
  assign cur_status = (err != ST_OK) ? err : (halted ? ST_HALT : ST_OK);

  bfie_tape #(.DEPTH(TAPE_DEPTH)) u_tape (
    .clk   (clk),
    .rst   (rst),
    .ctl   (tape_ctl),
    .addr  (tape_addr),
    .wdata (tape_wdata),
    .rdata (tape_rdata),
    .busy  (tape_busy)
  );

  // Program memory: load writes, registered fetch reads.
  always_ff @(posedge clk) begin
    if (prog_we) begin
      prog_mem[prog_waddr] <= req.program_byte;
    end
    if (prog_re) begin
      prog_rdata <= prog_mem[prog_raddr];
    end
  end

  // Loop stack: a push reads its own slot back so the read register holds the top.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata <= (stk_we && (stk_waddr == stk_raddr)) ? stk_wdata : stk_mem[stk_raddr];
    end
  end

  // Sequencer and command execution.
  always_comb begin
    state_next     = state;
    pc_next        = pc;
    head_next      = head;
    depth_next     = depth;
    halted_next    = halted;
    err_next       = err;
    emit_next      = emit;
    emit_byte_next = emit_byte;
    scan_addr_next = scan_addr;
    nest_next      = nest;
    in_byte_next   = in_byte;
    prog_re        = 1'b0;
    prog_raddr     = pc;
    stk_we         = 1'b0;
    stk_re         = 1'b0;
    stk_waddr      = depth[SW-1:0];
    stk_raddr      = depth[SW-1:0];
    stk_wdata      = pc;
    tape_ctl       = '0;
    tape_addr      = head;
    tape_wdata     = tape_rdata;
    load_out       = 1'b0;

    unique case (state)
      S_CLEAR: begin
        if (!tape_busy) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE, S_DONE: begin
        if (state == S_DONE && out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
        if (accept) begin
          emit_next      = 1'b0;
          emit_byte_next = '0;
          err_next       = ST_OK;
          // The input byte is held here, as the source may move on after the handshake.
          in_byte_next   = req.read_value;
          if (req.req_type == REQ_STEP && !halted) begin
            prog_re    = 1'b1;
            prog_raddr = pc;
            state_next = S_EXEC;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_EXEC: begin
        state_next = S_DONE;
        unique case (prog_rdata)
          OP_HALT: begin
            halted_next = 1'b1;
          end
          OP_PLUS, OP_MINUS, OP_IN: begin
            tape_ctl.wr = 1'b1;
            tape_ctl.rd = 1'b1;
            if (prog_rdata == OP_PLUS) begin
              tape_wdata = tape_rdata + BYTE_W'(1);
            end else if (prog_rdata == OP_MINUS) begin
              tape_wdata = tape_rdata - BYTE_W'(1);
            end else begin
              tape_wdata = in_byte;
            end
            if (pc_at_last) halted_next = 1'b1;
            else pc_next = pc + PW'(1);
          end
          OP_RIGHT, OP_LEFT: begin
            if (prog_rdata == OP_RIGHT) begin
              head_next = (head == HEAD_LAST) ? '0 : head + HW'(1);
            end else begin
              head_next = (head == '0) ? HEAD_LAST : head - HW'(1);
            end
            // Fetch the new current cell into the tape read register.
            tape_ctl.rd = 1'b1;
            tape_addr   = head_next;
            if (pc_at_last) halted_next = 1'b1;
            else pc_next = pc + PW'(1);
          end
          OP_OUT: begin
            emit_next      = 1'b1;
            emit_byte_next = tape_rdata;
            if (pc_at_last) halted_next = 1'b1;
            else pc_next = pc + PW'(1);
          end
          OP_OPEN: begin
            if (tape_rdata != '0) begin
              if (!top_here && depth == DEPTH_MAX) begin
                halted_next = 1'b1;
                err_next    = ST_OVF;
              end else begin
                if (!top_here) begin
                  stk_we     = 1'b1;
                  stk_re     = 1'b1;
                  depth_next = depth + DW'(1);
                end
                if (pc_at_last) halted_next = 1'b1;
                else pc_next = pc + PW'(1);
              end
            end else begin
              // A bracket that is on top of the stack leaves it before the scan.
              if (top_here) begin
                depth_next = depth - DW'(1);
                stk_re     = 1'b1;
                stk_raddr  = depth_m2[SW-1:0];
              end
              if (pc_at_last) begin
                halted_next = 1'b1;
              end else begin
                prog_re        = 1'b1;
                prog_raddr     = pc + PW'(1);
                scan_addr_next = pc + PW'(1);
                nest_next      = '0;
                state_next     = S_SCAN;
              end
            end
          end
          OP_CLOSE: begin
            if (depth == '0) begin
              halted_next = 1'b1;
              err_next    = ST_UNF;
            end else if (tape_rdata != '0) begin
              pc_next = stk_rdata;
            end else begin
              depth_next = depth - DW'(1);
              stk_re     = 1'b1;
              stk_raddr  = depth_m2[SW-1:0];
              if (pc_at_last) halted_next = 1'b1;
              else pc_next = pc + PW'(1);
            end
          end
          default: begin
            if (pc_at_last) halted_next = 1'b1;
            else pc_next = pc + PW'(1);
          end
        endcase
      end

      S_SCAN: begin
        // One program byte per cycle; the next byte is fetched meanwhile.
        if (prog_rdata == OP_HALT) begin
          pc_next     = scan_addr;
          halted_next = 1'b1;
          state_next  = S_DONE;
        end else if (prog_rdata == OP_CLOSE && nest == '0) begin
          if (scan_at_last) begin
            pc_next     = PC_LAST;
            halted_next = 1'b1;
          end else begin
            pc_next = scan_addr + PW'(1);
          end
          state_next = S_DONE;
        end else begin
          if (prog_rdata == OP_OPEN) begin
            nest_next = nest + PW'(1);
          end else if (prog_rdata == OP_CLOSE) begin
            nest_next = nest - PW'(1);
          end
          if (scan_at_last) begin
            pc_next     = PC_LAST;
            halted_next = 1'b1;
            state_next  = S_DONE;
          end else begin
            prog_re        = 1'b1;
            prog_raddr     = scan_addr + PW'(1);
            scan_addr_next = scan_addr + PW'(1);
          end
        end
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Control and architectural registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      pc        <= '0;
      head      <= '0;
      depth     <= '0;
      halted    <= 1'b0;
      err       <= ST_OK;
      emit      <= 1'b0;
      emit_byte <= '0;
      scan_addr <= '0;
      nest      <= '0;
      in_byte   <= '0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      head      <= head_next;
      depth     <= depth_next;
      halted    <= halted_next;
      err       <= err_next;
      emit      <= emit_next;
      emit_byte <= emit_byte_next;
      scan_addr <= scan_addr_next;
      nest      <= nest_next;
      in_byte   <= in_byte_next;
    end
  end

  // Result register: holds one transaction until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.program_position <= pc_ext[PC_OUT_W-1:0];
      rsp.emit_valid       <= emit;
      rsp.emit_value       <= emit_byte;
      rsp.cell_now         <= tape_rdata;
      rsp.head_now         <= head_ext[HEAD_OUT_W-1:0];
      rsp.status           <= cur_status;
    end
  end

`ifndef SYNTH
  // The loop stack never holds more entries than it has slots.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_MAX)
    else $error("loop depth beyond stack size");

  // A load transaction leaves the execution state untouched.
  a_load_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_LOAD) |=> ($stable(pc) && $stable(head) && $stable(depth)))
    else $error("load changed execution state");

  // Once halted, the block stays halted.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted flag cleared");

  // A forward scan never touches the tape.
  a_scan_no_tape: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !tape_ctl.wr && !tape_ctl.rd)
    else $error("tape accessed during scan");
`endif

endmodule

// File: hw/rtl/bfie_tape.sv
// Tape cell memory with one read/write port, write-through read data and a
// zeroing sweep after reset. Depends on bfie_pkg for the port control struct.
module bfie_tape #(
  parameter int DEPTH = bfie_pkg::TAPE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bfie_pkg::tape_ctl_t       ctl,
  input  logic [AW-1:0]             addr,
  input  logic [bfie_pkg::BYTE_W-1:0] wdata,
  output logic [bfie_pkg::BYTE_W-1:0] rdata,
  output logic                      busy
);
  import bfie_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [AW-1:0]     clr_addr;
  logic              clearing;

  assign busy = clearing;

  // Sweep counter that zeroes every cell once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Cell array; a write is always paired with a read of the same cell.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (ctl.wr) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read data follows the current cell; it starts at zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      rdata <= '0;
    end else if (!clearing && ctl.rd) begin
      rdata <= ctl.wr ? wdata : mem[addr];
    end
  end

endmodule

// File: test/bf_instruction_executor_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for bf_instruction_executor_core: random tape programs are loaded and
// stepped through, and every result is checked against an in-bench predictor of the executor.
// Depends on bfie_pkg, bfie_req_if, bfie_rsp_if and the executor RTL.
module bf_instruction_executor_core_test;
  import bfie_pkg::*;

  localparam int CODE_N = CODE_DEPTH_DEF;
  localparam int TAPE_N = TAPE_DEPTH_DEF;
  localparam int STACK_N = STACK_DEPTH_DEF;
  // Two copies of the executor state: one steers stimulus, one checks results.
  localparam int PLAN_COPY = 0;
  localparam int CHECK_COPY = 1;
  localparam int RANDOM_ITEMS = 700;
  localparam int PHASE_LEN = 120;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 20;
  // Programs live below this address; stray loads go at or above it.
  localparam int SCRATCH_BASE = 2048;

  typedef struct packed {
    logic                  req_type;
    logic [LOAD_W-1:0]     load_address;
    logic [BYTE_W-1:0]     program_byte;
    logic [BYTE_W-1:0]     read_value;
  } exec_req_t;

  typedef struct packed {
    logic [PC_OUT_W-1:0]   program_position;
    logic                  emit_valid;
    logic [BYTE_W-1:0]     emit_value;
    logic [BYTE_W-1:0]     cell_now;
    logic [HEAD_OUT_W-1:0] head_now;
    logic [STATUS_W-1:0]   status;
  } exec_result_t;

  logic clk = 1'b0;
  logic rst;

  bfie_req_if req_ch ();
  bfie_rsp_if rsp_ch ();

  bf_instruction_executor_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Executor state, one copy per index.
  bit [7:0]  code_mem [2][CODE_N];
  bit [7:0]  tape_mem [2][TAPE_N];
  bit [11:0] loop_stack [2][STACK_N];
  int        loop_depth [2];
  int        prog_ctr [2];
  int        head_pos [2];
  bit        halted [2];

  exec_req_t    pending_requests [$];
  exec_result_t predicted_outcomes [$];
  bit [7:0]     fragment [$];
  int           total_requests;
  int           accepted_requests;
  int           quiet_cycles;
  int           errors;

  always #6 clk = ~clk;

  // Move the program counter on by one; running off the end halts.
  function automatic void advance_pc(int k);
    if (prog_ctr[k] + 1 >= CODE_N) begin
      prog_ctr[k] = CODE_N - 1;
      halted[k] = 1'b1;
    end else begin
      prog_ctr[k]++;
    end
  endfunction

  // Walk forward to the bracket that closes the loop at the program counter.
  function automatic void skip_loop(int k);
    int q;
    int nest;
    q = prog_ctr[k];
    nest = 0;
    while (1) begin
      if (q + 1 >= CODE_N) begin
        prog_ctr[k] = CODE_N - 1;
        halted[k] = 1'b1;
        return;
      end
      q++;
      if (code_mem[k][q] == OP_HALT) begin
        prog_ctr[k] = q;
        halted[k] = 1'b1;
        return;
      end
      if (code_mem[k][q] == OP_OPEN) begin
        nest++;
      end else if (code_mem[k][q] == OP_CLOSE) begin
        if (nest == 0) begin
          prog_ctr[k] = q;
          advance_pc(k);
          return;
        end
        nest--;
      end
    end
  endfunction

  // Apply one request to state copy k and return the result it produces.
  function automatic exec_result_t execute_request(int k, exec_req_t r);
    exec_result_t res;
    bit [7:0] op;
    bit [7:0] cell_val;
    bit top_here;
    res = '0;
    if (r.req_type == REQ_LOAD) begin
      code_mem[k][r.load_address] = r.program_byte;
    end else if (!halted[k]) begin
      op = code_mem[k][prog_ctr[k]];
      cell_val = tape_mem[k][head_pos[k]];
      top_here = loop_depth[k] > 0 && loop_stack[k][loop_depth[k] - 1] == prog_ctr[k];
      case (op)
        OP_HALT: halted[k] = 1'b1;
        OP_OPEN: begin
          if (cell_val == 8'd0) begin
            if (top_here) loop_depth[k]--;
            skip_loop(k);
          end else if (!top_here && loop_depth[k] >= STACK_N) begin
            halted[k] = 1'b1;
            res.status = ST_OVF;
          end else begin
            if (!top_here) begin
              loop_stack[k][loop_depth[k]] = PC_OUT_W'(prog_ctr[k]);
              loop_depth[k]++;
            end
            advance_pc(k);
          end
        end
        OP_CLOSE: begin
          if (loop_depth[k] == 0) begin
            halted[k] = 1'b1;
            res.status = ST_UNF;
          end else if (cell_val != 8'd0) begin
            prog_ctr[k] = int'(loop_stack[k][loop_depth[k] - 1]);
          end else begin
            loop_depth[k]--;
            advance_pc(k);
          end
        end
        default: begin
          case (op)
            OP_PLUS:  tape_mem[k][head_pos[k]] = cell_val + 8'd1;
            OP_MINUS: tape_mem[k][head_pos[k]] = cell_val - 8'd1;
            OP_RIGHT: head_pos[k] = (head_pos[k] + 1) % TAPE_N;
            OP_LEFT:  head_pos[k] = (head_pos[k] == 0) ? TAPE_N - 1 : head_pos[k] - 1;
            OP_OUT: begin
              res.emit_valid = 1'b1;
              res.emit_value = cell_val;
            end
            OP_IN:    tape_mem[k][head_pos[k]] = r.read_value;
            default: ;
          endcase
          advance_pc(k);
        end
      endcase
    end
    if (res.status == ST_OK && halted[k]) res.status = ST_HALT;
    res.program_position = PC_OUT_W'(prog_ctr[k]);
    res.head_now = HEAD_OUT_W'(head_pos[k]);
    res.cell_now = tape_mem[k][head_pos[k]];
    return res;
  endfunction

  // Queue a request and run it on the planning copy so later choices see its effect.
  function automatic void push_request(exec_req_t r);
    exec_result_t ignored;
    pending_requests.push_back(r);
    ignored = execute_request(PLAN_COPY, r);
  endfunction

  function automatic void add_load(int addr, bit [7:0] b);
    exec_req_t r;
    r.req_type = REQ_LOAD;
    r.load_address = LOAD_W'(addr);
    r.program_byte = b;
    r.read_value = BYTE_W'($urandom_range(255, 0));
    push_request(r);
  endfunction

  // A load into scratch memory now and then, with fully random content.
  function automatic void maybe_stray_load();
    if ($urandom_range(99, 0) < 8) add_load(int'($urandom_range(CODE_N - 1, SCRATCH_BASE)),
                                           8'($urandom_range(255, 0)));
  endfunction

  // Queue a step. A negative value lets the input byte be chosen here: a read that closes a
  // loop is zero half the time so loops end, other reads are zero at least a quarter of the time.
  function automatic void add_step(int rv);
    exec_req_t r;
    int p;
    p = prog_ctr[PLAN_COPY];
    r.req_type = REQ_STEP;
    r.load_address = LOAD_W'($urandom_range(CODE_N - 1, 0));
    r.program_byte = BYTE_W'($urandom_range(255, 0));
    if (rv >= 0) begin
      r.read_value = BYTE_W'(rv);
    end else if (code_mem[PLAN_COPY][p] == OP_IN && p < CODE_N - 1 &&
                 code_mem[PLAN_COPY][p + 1] == OP_CLOSE) begin
      r.read_value = BYTE_W'(($urandom_range(1, 0) == 0) ? 0 : $urandom_range(255, 1));
    end else if (code_mem[PLAN_COPY][p] == OP_IN) begin
      r.read_value = BYTE_W'(($urandom_range(3, 0) == 0) ? 0 : $urandom_range(255, 0));
    end else begin
      r.read_value = BYTE_W'($urandom_range(255, 0));
    end
    push_request(r);
  endfunction

  // Build a balanced program body; every loop ends with a read right before its close.
  function automatic void build_body(int lvl);
    int n;
    int pick;
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(9, 0);
      if (pick >= 8 && lvl < 2) begin
        fragment.push_back(OP_OPEN);
        build_body(lvl + 1);
        fragment.push_back(OP_IN);
        fragment.push_back(OP_CLOSE);
      end else begin
        case (pick % 8)
          0: fragment.push_back(OP_PLUS);
          1: fragment.push_back(OP_MINUS);
          2: fragment.push_back(OP_RIGHT);
          3: fragment.push_back(OP_LEFT);
          4: fragment.push_back(OP_OUT);
          5: fragment.push_back(OP_IN);
          6: fragment.push_back(8'($urandom_range(255, 8'h5E)));
          default: fragment.push_back(8'($urandom_range(8'h2A, 1)));
        endcase
      end
    end
  endfunction

  // Load the fragment at the program counter with a zero byte behind it, then step through it.
  function automatic void run_fragment();
    int base;
    int stop_at;
    base = prog_ctr[PLAN_COPY];
    stop_at = base + fragment.size();
    add_load(stop_at, OP_HALT);
    for (int i = 0; i < fragment.size(); i++) begin
      maybe_stray_load();
      add_load(base + i, fragment[i]);
    end
    while (prog_ctr[PLAN_COPY] != stop_at && !halted[PLAN_COPY]) begin
      maybe_stray_load();
      add_step(-1);
    end
  endfunction

  // Percentage of cycles that the sender idles or the receiver stalls in the current phase.
  function automatic int idle_pct(bit sender);
    case ((accepted_requests / PHASE_LEN) % 4)
      1: return sender ? 62 : 0;
      2: return sender ? 0 : 62;
      3: return 34;
      default: return 0;
    endcase
  endfunction

  // Request driver: hold a transaction until it is taken, then present the next one.
  always @(posedge clk) begin
    exec_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= REQ_LOAD;
      req_ch.load_address <= '0;
      req_ch.program_byte <= '0;
      req_ch.read_value <= '0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_requests.size() != 0 && $urandom_range(99, 0) >= idle_pct(1'b1)) begin
        nxt = pending_requests.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.req_type <= nxt.req_type;
        req_ch.load_address <= nxt.load_address;
        req_ch.program_byte <= nxt.program_byte;
        req_ch.read_value <= nxt.read_value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99, 0) >= idle_pct(1'b0));
    end
  end

  // Monitor: check each result transaction, then predict from each request transaction.
  always @(posedge clk) begin
    exec_result_t got;
    exec_result_t want;
    exec_req_t taken;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.program_position = rsp_ch.program_position;
        got.emit_valid = rsp_ch.emit_valid;
        got.emit_value = rsp_ch.emit_value;
        got.cell_now = rsp_ch.cell_now;
        got.head_now = rsp_ch.head_now;
        got.status = rsp_ch.status;
        if (predicted_outcomes.size() == 0) begin
          $display("%0t: result with none outstanding, got %h", $time, got);
          errors++;
        end else begin
          want = predicted_outcomes.pop_front();
          if (got !== want) errors++;
          if (got.program_position !== want.program_position)
            $display("%0t: program_position expected %0d got %0d", $time,
                     want.program_position, got.program_position);
          if (got.emit_valid !== want.emit_valid)
            $display("%0t: emit_valid expected %0d got %0d", $time, want.emit_valid,
                     got.emit_valid);
          if (got.emit_value !== want.emit_value)
            $display("%0t: emit_value expected %0d got %0d", $time, want.emit_value,
                     got.emit_value);
          if (got.cell_now !== want.cell_now)
            $display("%0t: cell_now expected %0d got %0d", $time, want.cell_now,
                     got.cell_now);
          if (got.head_now !== want.head_now)
            $display("%0t: head_now expected %0d got %0d", $time, want.head_now,
                     got.head_now);
          if (got.status !== want.status)
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        taken.req_type = req_ch.req_type;
        taken.load_address = req_ch.load_address;
        taken.program_byte = req_ch.program_byte;
        taken.read_value = req_ch.read_value;
        predicted_outcomes.push_back(execute_request(CHECK_COPY, taken));
        accepted_requests++;
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Stimulus plan, reset and end of run.
  initial begin
    rst = 1'b1;

    // Directed: wrap the head and the cell both ways, every command but the zero byte, an
    // ignored byte, and loads at the address extremes.
    add_load(CODE_N - 1, 8'hFF);
    add_load(SCRATCH_BASE, 8'h00);
    fragment = '{OP_LEFT, OP_MINUS, OP_OUT, OP_PLUS, OP_RIGHT, 8'h78, OP_IN, OP_OUT,
                 OP_OPEN, OP_IN, OP_CLOSE};
    run_fragment();

    // Random well-formed programs with random content.
    while (pending_requests.size() < RANDOM_ITEMS) begin
      fragment.delete();
      build_body(0);
      run_fragment();
    end

    // The run ends in one of the halting cases, picked at random.
    case ($urandom_range(3, 0))
      0: add_step(-1);
      1: begin
        add_load(prog_ctr[PLAN_COPY] + 1, OP_HALT);
        add_load(prog_ctr[PLAN_COPY], OP_CLOSE);
        add_step(-1);
      end
      2: begin
        // Nest one more loop than the stack holds.
        add_load(prog_ctr[PLAN_COPY] + STACK_N + 2, OP_HALT);
        add_load(prog_ctr[PLAN_COPY], OP_IN);
        for (int i = 1; i <= STACK_N + 1; i++) add_load(prog_ctr[PLAN_COPY] + i, OP_OPEN);
        add_step(int'($urandom_range(255, 1)));
        while (!halted[PLAN_COPY]) add_step(-1);
      end
      default: begin
        // A loop entered on a zero cell with no closing bracket before the zero byte.
        add_load(prog_ctr[PLAN_COPY] + 3, OP_HALT);
        add_load(prog_ctr[PLAN_COPY], OP_IN);
        add_load(prog_ctr[PLAN_COPY] + 1, OP_OPEN);
        add_load(prog_ctr[PLAN_COPY] + 2, OP_PLUS);
        add_step(0);
        add_step(-1);
      end
    endcase
    // Steps and a load after the halt.
    add_step(-1);
    add_load(int'($urandom_range(CODE_N - 1, SCRATCH_BASE)), 8'($urandom_range(255, 0)));
    add_step(-1);
    add_step(-1);
    total_requests = pending_requests.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while ((accepted_requests < total_requests || predicted_outcomes.size() != 0) &&
           quiet_cycles < WATCHDOG_LIMIT)
      @(negedge clk);

    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (errors == 0 && predicted_outcomes.size() == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
    end
    $finish;
  end

endmodule
